// ----- hdl/iirdf_pkg.sv -----
package iirdf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int ORDER_W   = 3;
  localparam int MAX_TAPS  = 4;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // Seven products at most, so three bits of growth, plus one spare.
  localparam int ACC_W     = PROD_W + 4;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [2:0] {
    REG_ORDER  = 3'd0,
    REG_FEED_0 = 3'd1,
    REG_FEED_1 = 3'd2,
    REG_FEED_2 = 3'd3,
    REG_FEED_3 = 3'd4,
    REG_BACK_1 = 3'd5,
    REG_BACK_2 = 3'd6,
    REG_BACK_3 = 3'd7
  } reg_idx_t;

  localparam logic [ORDER_W-1:0] ORDER_RESET  = 3'd4;
  localparam coef_t              FEED0_RESET  = 16'sd16384;

endpackage

// ----- hdl/iir_filter_direct_form_top.sv -----
// Channel   Dir  Transfer / payload
// --------  ---  ----------------------------------------------------------
// s_*       in   s_tvalid & s_tready; s_tdata = sample_in
// m_*       out  m_tvalid & m_tready; m_tdata = filtered_out, m_tuser = clipped
// APB       in   write at psel & penable & pwrite (pready tied high)
//
// One sample per clock sustained while m_tready stays high; a sample passes through
// the input register, then the result register. The clock period is set by
// the recursive path: seven 16x16 products, their sum, rounding and saturation
// must all settle combinationally because y[n] feeds the next sample.
// Reset clears the histories and loads the register defaults.
// With m_tready low the result holds and one more sample is buffered; then s_tready
// drops.
module iir_filter_direct_form_top #(
  parameter int ORDER = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  iirdf_pkg::sample_t               s_tdata,   // [15:0] sample_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output iirdf_pkg::sample_t               m_tdata,   // [15:0] filtered_out
  output logic                             m_tuser,   // [0] clipped
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iirdf_pkg::APB_AW-1:0]     paddr,
  input  logic [iirdf_pkg::APB_DW-1:0]     pwdata,
  output logic [iirdf_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);
  import iirdf_pkg::*;

  localparam int RW = ACC_W - FRAC_BITS;
  localparam logic signed [RW-1:0] R_MAX = RW'(32767);
  localparam logic signed [RW-1:0] R_MIN = -RW'(32768);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

  // Configuration registers
  logic [ORDER_W-1:0] order_in_use;
  coef_t              feed_coef [0:MAX_TAPS-1];
  coef_t              back_coef [1:MAX_TAPS-1];

  // Histories
  sample_t in_hist  [0:ORDER-1];
  sample_t out_hist [0:ORDER-1];
  sample_t in_hist_next  [0:ORDER-1];
  sample_t out_hist_next [0:ORDER-1];

  // Input register and result register
  logic    in_valid;
  sample_t in_sample;
  logic    advance;

  logic [ORDER_W-1:0]       taps;
  logic signed [PROD_W-1:0] feed_prod [0:ORDER-1];
  logic signed [PROD_W-1:0] back_prod [0:ORDER-1];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  biased;
  logic signed [RW-1:0]     rounded;
  sample_t                  y;
  logic                     clip;

  reg_idx_t reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use <= ORDER_RESET;
      feed_coef[0] <= FEED0_RESET;
      for (int k = 1; k < MAX_TAPS; k++) begin
        feed_coef[k] <= '0;
        back_coef[k] <= '0;
      end
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ORDER:  order_in_use <= pwdata[ORDER_W-1:0];
        REG_FEED_0: feed_coef[0] <= pwdata[COEF_W-1:0];
        REG_FEED_1: feed_coef[1] <= pwdata[COEF_W-1:0];
        REG_FEED_2: feed_coef[2] <= pwdata[COEF_W-1:0];
        REG_FEED_3: feed_coef[3] <= pwdata[COEF_W-1:0];
        REG_BACK_1: back_coef[1] <= pwdata[COEF_W-1:0];
        REG_BACK_2: back_coef[2] <= pwdata[COEF_W-1:0];
        REG_BACK_3: back_coef[3] <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER:  prdata = APB_DW'(order_in_use);
      REG_FEED_0: prdata = APB_DW'(feed_coef[0]);
      REG_FEED_1: prdata = APB_DW'(feed_coef[1]);
      REG_FEED_2: prdata = APB_DW'(feed_coef[2]);
      REG_FEED_3: prdata = APB_DW'(feed_coef[3]);
      REG_BACK_1: prdata = APB_DW'(back_coef[1]);
      REG_BACK_2: prdata = APB_DW'(back_coef[2]);
      REG_BACK_3: prdata = APB_DW'(back_coef[3]);
      default:    prdata = '0;
    endcase
  end

  // The buffered sample moves into the filter whenever the result register is free.
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata;
    end
  end

  // An order of zero behaves as one tap; anything above ORDER is capped.
  always_comb begin
    if (order_in_use == '0) begin
      taps = ORDER_W'(1);
    end else if (order_in_use > ORDER_W'(ORDER)) begin
      taps = ORDER_W'(ORDER);
    end else begin
      taps = order_in_use;
    end
  end

  // Only the slots in use shift; the rest keep their contents.
  always_comb begin
    in_hist_next[0]  = in_sample;
    out_hist_next[0] = out_hist[0];
    for (int k = 1; k < ORDER; k++) begin
      if (ORDER_W'(k) < taps) begin
        in_hist_next[k]  = in_hist[k-1];
        out_hist_next[k] = out_hist[k-1];
      end else begin
        in_hist_next[k]  = in_hist[k];
        out_hist_next[k] = out_hist[k];
      end
    end
  end

  always_comb begin
    feed_prod[0] = in_hist_next[0] * feed_coef[0];
    back_prod[0] = '0;
    acc          = ACC_W'(feed_prod[0]);
    for (int k = 1; k < ORDER; k++) begin
      feed_prod[k] = in_hist_next[k] * feed_coef[k];
      back_prod[k] = out_hist_next[k] * back_coef[k];
      if (ORDER_W'(k) < taps) begin
        acc = acc + ACC_W'(feed_prod[k]) - ACC_W'(back_prod[k]);
      end
    end
    // Round half up, then floor shift back to integer scale.
    biased  = acc + ROUND_HALF;
    rounded = biased[ACC_W-1:FRAC_BITS];
    if (rounded > R_MAX) begin
      y    = sample_t'(R_MAX);
      clip = 1'b1;
    end else if (rounded < R_MIN) begin
      y    = sample_t'(R_MIN);
      clip = 1'b1;
    end else begin
      y    = rounded[SAMPLE_W-1:0];
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        in_hist[k]  <= '0;
        out_hist[k] <= '0;
      end
    end else if (advance) begin
      in_hist <= in_hist_next;
      for (int k = 1; k < ORDER; k++) begin
        out_hist[k] <= out_hist_next[k];
      end
      out_hist[0] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= y;
      m_tuser <= clip;
    end
  end

endmodule

// ----- tb/sv/iir_filter_direct_form_top_tb.sv -----
module iir_filter_direct_form_top_tb;
  import iirdf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 210;
  localparam int DRAIN_CYCLES  = 6;

  typedef struct packed {
    sample_t filtered;
    logic    clipped;
  } filter_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    s_tvalid = 1'b0;
  logic    s_tready;
  sample_t s_tdata = '0;
  logic    m_tvalid;
  logic    m_tready = 1'b0;
  sample_t m_tdata;
  logic    m_tuser;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic    pready;

  // Filter settings and histories as the block should hold them.
  logic [ORDER_W-1:0] order_setting;
  coef_t   feed_coef [MAX_TAPS];
  coef_t   back_coef [MAX_TAPS];
  sample_t x_hist [MAX_TAPS];
  sample_t y_hist [MAX_TAPS];

  sample_t        samples_to_send [$];
  filter_result_t pending_outputs [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int samples_pushed = 0;
  int samples_accepted = 0;
  int results_checked = 0;
  int clipped_seen = 0;
  int input_stall_cycles = 0;
  int settings_used = 1;
  int cycle_count = 0;

  iir_filter_direct_form_top #(.ORDER(MAX_TAPS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [15:0] sample_in
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [15:0] filtered_out
    .m_tuser  (m_tuser),    // [0] clipped
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Shift the histories, then sum the products with Q2.14 coefficients, round half up and saturate.
  function automatic void run_filter_step(input sample_t x, output sample_t y,
                                          output logic clip);
    int     taps;
    longint acc;
    longint rounded;
    taps = (order_setting == 0) ? 1 : (order_setting > MAX_TAPS) ? MAX_TAPS
                                                                : int'(order_setting);
    for (int k = taps - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    acc = longint'(feed_coef[0]) * longint'(x_hist[0]);
    for (int k = 1; k < taps; k++) begin
      acc += longint'(feed_coef[k]) * longint'(x_hist[k]);
      acc -= longint'(back_coef[k]) * longint'(y_hist[k]);
    end
    rounded = (acc + 64'sd8192) >>> FRAC_BITS;
    clip = 1'b1;
    if (rounded > 32767) begin
      y = 16'sh7FFF;
    end else if (rounded < -32768) begin
      y = 16'sh8000;
    end else begin
      y = rounded[15:0];
      clip = 1'b0;
    end
    y_hist[0] = y;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= samples_to_send.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // A requested hold keeps tready low while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Outputs are checked before the predictor runs on this edge's input transfer.
  always @(posedge clk) begin : result_check
    filter_result_t want;
    sample_t        y;
    logic           clip;
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stall_cycles++;
      if (m_tvalid && m_tready) begin
        if (pending_outputs.size() == 0) begin
          flag_error($sformatf("unexpected result %0d clipped=%0b", m_tdata, m_tuser));
        end else begin
          want = pending_outputs.pop_front();
          if (m_tdata !== want.filtered)
            flag_error($sformatf("filtered_out %0d, expected %0d", m_tdata, want.filtered));
          if (m_tuser !== want.clipped)
            flag_error($sformatf("clipped %0b, expected %0b", m_tuser, want.clipped));
          results_checked++;
          if (want.clipped) clipped_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        run_filter_step(s_tdata, y, clip);
        pending_outputs.push_back('{filtered: y, clipped: clip});
        samples_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
               pending_outputs.size());
      $display("** iir_filter_direct_form_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ORDER:  order_setting = value[ORDER_W-1:0];
      REG_FEED_0: feed_coef[0] = value;
      REG_FEED_1: feed_coef[1] = value;
      REG_FEED_2: feed_coef[2] = value;
      REG_FEED_3: feed_coef[3] = value;
      REG_BACK_1: back_coef[1] = value;
      REG_BACK_2: back_coef[2] = value;
      REG_BACK_3: back_coef[3] = value;
      default: ;
    endcase
  endtask

  task automatic offer(input sample_t v);
    samples_to_send.push_back(v);
    samples_pushed++;
  endtask

  task automatic begin_phase(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // The test offers no new samples until every expected result is back.
  task automatic wait_idle();
    @(negedge clk);
    while (samples_accepted != samples_pushed || pending_outputs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic coef_t pick_coef(input int style, input bit feedback);
    case (style)
      0: return feedback ? coef_t'(int'($urandom_range(4096)) - 2048)
                         : coef_t'(int'($urandom_range(16384)) - 8192);
      1: return coef_t'($urandom);
      default:
        case ($urandom_range(4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh4000;
          default: return 16'shC000;
        endcase
    endcase
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end else if (r < 25) begin
      return sample_t'(int'($urandom_range(512)) - 256);
    end
    return sample_t'($urandom);
  endfunction

  initial begin
    logic [ORDER_W-1:0] orders [RANDOM_PHASES];
    orders = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd6, 3'd4};
    order_setting = ORDER_RESET;
    for (int k = 0; k < MAX_TAPS; k++) begin
      feed_coef[k] = '0;
      back_coef[k] = '0;
      x_hist[k]    = '0;
      y_hist[k]    = '0;
    end
    feed_coef[0] = FEED0_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings pass the sample straight through.
    begin_phase(0, 0);
    offer(16'sh0000); offer(16'sh7FFF); offer(16'sh8000); offer(16'sh0001);
    offer(16'shFFFF); offer(16'sh5555); offer(16'shAAAA); offer(16'sd12345);
    wait_idle();

    // Gain near two with a negative second tap drives both saturation limits.
    write_reg(REG_ORDER, 16'd2);
    write_reg(REG_FEED_0, 16'h7FFF);
    write_reg(REG_FEED_1, 16'h8000);
    settings_used++;
    begin_phase(0, 0);
    offer(16'sh7FFF); offer(16'sh7FFF); offer(16'sh8000); offer(16'sh8000);
    offer(16'sd100);
    wait_idle();

    // Order zero acts as one tap; a gain of one half shows round half up.
    write_reg(REG_ORDER, 16'd0);
    write_reg(REG_FEED_0, 16'h2000);
    settings_used++;
    begin_phase(0, 0);
    offer(16'sd1); offer(-16'sd1); offer(16'sd3); offer(-16'sd3);
    wait_idle();

    // Order above the tap count acts as four; strong feedback makes the output grow in magnitude.
    write_reg(REG_ORDER, 16'd7);
    write_reg(REG_FEED_0, 16'h4000);
    write_reg(REG_BACK_1, 16'h8000);
    settings_used++;
    begin_phase(0, 0);
    offer(16'sd1000); offer(16'sd0); offer(16'sd0); offer(16'sd0);
    offer(16'sd0); offer(-16'sd7);
    wait_idle();

    // Orders change between phases without a reset, so stale history slots come back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_ORDER, {13'd0, orders[p]});
      for (int i = int'(REG_FEED_0); i <= int'(REG_BACK_3); i++)
        write_reg(reg_idx_t'(i), pick_coef(p % 3, i >= int'(REG_BACK_1)));
      settings_used++;
      if (p < 3) begin_phase(30, 63);
      else if (p < 6) begin_phase(63, 30);
      else begin_phase(0, 0);
      for (int n = 0; n < PHASE_SAMPLES; n++) offer(pick_sample());
      if (p == 1 || p == 6) hold_token++;
      wait_idle();
    end

    $display("Checked %0d filtered samples over %0d coefficient settings, %0d of them clipped.",
             results_checked, settings_used, clipped_seen);
    $display("The input was held off for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (errors == 0) begin
      $display("** iir_filter_direct_form_top: PASSED **");
    end else begin
      $display("** iir_filter_direct_form_top: FAILED **");
    end
    $finish;
  end

endmodule
